/* rtl/core/xcpc_pkg.sv */
package xcpc_pkg;

	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = 8;

	localparam logic [CFG_INDEX_W-1:0] CFG_MODE      = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_FIXED_KEY = 1'd1;

	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [7:0] random_key;
		logic       first_byte;
		logic       last_byte;
	} xcpc_req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       end_of_packet;
		logic       checksum_ok;
	} xcpc_rsp_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] fixed_key;
	} xcpc_cfg_t;

endpackage

/* rtl/core/xcpc_cfg_regs.sv */
module xcpc_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [xcpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [xcpc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output xcpc_pkg::xcpc_cfg_t                 cfg
);

	xcpc_pkg::xcpc_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				xcpc_pkg::CFG_MODE:      cfg_q.mode      <= cfg_wdata[0];
				xcpc_pkg::CFG_FIXED_KEY: cfg_q.fixed_key <= cfg_wdata[7:0];
				default:                 cfg_q           <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/core/xcpc_chain.sv */
module xcpc_chain (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  xcpc_pkg::xcpc_req_t req,
	input  xcpc_pkg::xcpc_cfg_t cfg,
	output xcpc_pkg::xcpc_rsp_t rsp
);

	logic [7:0] pos_q, inner_q, outer_q, key_q, sum_q, chk_q;

	logic [7:0] pos, inner, outer, key, sum_base;
	logic [7:0] inner_mask, outer_mask;
	logic [7:0] enc_p, enc_e, dec_p, dec_plain;
	logic [7:0] inner_nxt, outer_nxt, sum_nxt, chk_nxt;
	logic       decode;

	assign decode   = (cfg.mode == xcpc_pkg::MODE_DECODE);
	assign pos      = req.first_byte ? 8'd0 : pos_q;
	assign inner    = req.first_byte ? 8'd0 : inner_q;
	assign outer    = req.first_byte ? 8'd0 : outer_q;
	assign key      = req.first_byte ? req.random_key : key_q;
	assign sum_base = req.first_byte ? 8'd0 : sum_q;

	assign inner_mask = inner + key + pos + 8'd1;
	assign outer_mask = outer + cfg.fixed_key + pos + 8'd1;

	assign enc_p     = req.data_byte ^ inner_mask;
	assign enc_e     = enc_p ^ outer_mask;
	assign dec_p     = req.data_byte ^ outer_mask;
	assign dec_plain = dec_p ^ inner_mask;

	always_comb begin
		if (decode) begin
			inner_nxt = dec_p;
			outer_nxt = req.data_byte;
			if (req.first_byte) begin
				sum_nxt = sum_base;
				chk_nxt = dec_plain;
			end else begin
				sum_nxt = sum_base + dec_plain;
				chk_nxt = chk_q;
			end
			rsp.out_byte    = dec_plain;
			rsp.checksum_ok = req.last_byte && (sum_nxt == chk_nxt);
		end else begin
			inner_nxt       = enc_p;
			outer_nxt       = enc_e;
			sum_nxt         = sum_base;
			chk_nxt         = chk_q;
			rsp.out_byte    = enc_e;
			rsp.checksum_ok = 1'b1;
		end
		rsp.end_of_packet = req.last_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			inner_q <= '0;
			outer_q <= '0;
			key_q   <= '0;
			sum_q   <= '0;
			chk_q   <= '0;
		end else if (step) begin
			pos_q   <= pos + 8'd1;
			inner_q <= inner_nxt;
			outer_q <= outer_nxt;
			key_q   <= key;
			sum_q   <= sum_nxt;
			chk_q   <= chk_nxt;
		end
	end

endmodule

/* rtl/core/xor_chain_packet_cipher_core.sv */
// Two-layer chained XOR byte cipher for the checksum-plus-payload region of a
// packet. Mode 0 enciphers, mode 1 deciphers and checks the payload sum against
// the deciphered checksum on the last byte. A request beat lands in an input
// register, the cipher step runs combinationally from there, and the result sits
// in an output register. While the response side does not stall, one beat per
// cycle is sustained, as the 8-bit chain feedback from each byte to the next
// is combinational. A response is valid once its request has passed the input
// and output registers. Write configuration only while no beat is in flight.
module xor_chain_packet_cipher_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  xcpc_pkg::xcpc_req_t                 req_beat,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output xcpc_pkg::xcpc_rsp_t                 rsp_beat,
	input  logic                                cfg_we,
	input  logic [xcpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [xcpc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	xcpc_pkg::xcpc_cfg_t cfg;
	xcpc_pkg::xcpc_req_t req_s1;
	xcpc_pkg::xcpc_rsp_t rsp_nxt, rsp_q;
	logic                valid_s1, rsp_valid_q;
	logic                out_free, step, req_take;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign step      = valid_s1 && out_free;
	assign req_stall = valid_s1 && !out_free;
	assign req_take  = req_valid && !req_stall;

	xcpc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	xcpc_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.req    (req_s1),
		.cfg    (cfg),
		.rsp    (rsp_nxt)
	);

	// hold the input beat until the cipher step consumes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_take) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			req_s1 <= req_beat;
		end
	end

	// advance the result into the output register when it is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_beat  = rsp_q;

endmodule

/* rtl/core/xcpc_checker.sv */
module xcpc_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	input  logic                                req_stall,
	input  logic                                rsp_valid,
	input  logic                                rsp_stall,
	input  xcpc_pkg::xcpc_rsp_t                 rsp_beat,
	input  logic                                cfg_we,
	input  logic [xcpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [xcpc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	logic       mode_q;
	logic [1:0] open_q;
	logic       req_take, rsp_take;

	assign req_take = req_valid && !req_stall;
	assign rsp_take = rsp_valid && !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= xcpc_pkg::MODE_ENCODE;
			open_q <= '0;
		end else begin
			if (cfg_we && cfg_index == xcpc_pkg::CFG_MODE) begin
				mode_q <= cfg_wdata[0];
			end
			open_q <= open_q + {1'b0, req_take} - {1'b0, rsp_take};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_beat))
		else $error("response beat dropped or changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && mode_q == xcpc_pkg::MODE_ENCODE |-> rsp_beat.checksum_ok)
		else $error("encode beat without checksum_ok");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && mode_q == xcpc_pkg::MODE_DECODE && !rsp_beat.end_of_packet
		|-> !rsp_beat.checksum_ok)
		else $error("decode checksum_ok outside the last byte");

	assert property (@(posedge clk) disable iff (!arst_n)
		open_q != 2'd3 && (!rsp_valid || open_q != 2'd0))
		else $error("response without request or more than two beats in flight");

	assert property (@(posedge clk) disable iff (!arst_n)
		open_q == 2'd2 && !rsp_take |-> req_stall)
		else $error("request taken with both stages full");

endmodule

bind xor_chain_packet_cipher_core xcpc_checker u_xcpc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_beat  (rsp_beat),
	.cfg_we    (cfg_we),
	.cfg_index (cfg_index),
	.cfg_wdata (cfg_wdata)
);
